// ===== rtl/cos_pkg.sv =====
// Shared widths, item types and codes for the circle overlap separation block
`default_nettype none
package cos_pkg;

  localparam int CoordBits = 24;
  localparam int FracBits  = 8;
  localparam int RadBits   = CoordBits - 1;
  localparam int MagBits   = CoordBits + 1;
  localparam int SqBits    = 2 * MagBits + 1;
  localparam int AmtBits   = ((RadBits > FracBits) ? RadBits : FracBits) + 1;
  localparam int DivBits   = RadBits + 1;
  localparam int NumBits   = RadBits + AmtBits + 1;
  localparam int RemBits   = RadBits + 2;

  localparam logic [1:0] ACT_OBSTACLE = 2'd0;
  localparam logic [1:0] ACT_BODY     = 2'd1;
  localparam logic [1:0] ACT_SHARE    = 2'd2;

  typedef struct packed {
    logic [1:0]                  action;
    logic signed [CoordBits-1:0] obstacle_x;
    logic signed [CoordBits-1:0] obstacle_y;
    logic signed [CoordBits-1:0] obstacle_z;
    logic [RadBits-1:0]          obstacle_height;
    logic signed [CoordBits-1:0] body_x;
    logic signed [CoordBits-1:0] body_y;
    logic signed [CoordBits-1:0] body_z;
    logic [RadBits-1:0]          body_height;
  } in_t;

  typedef struct packed {
    logic                        separated;
    logic signed [CoordBits-1:0] obstacle_dx;
    logic signed [CoordBits-1:0] obstacle_dz;
    logic signed [CoordBits-1:0] body_dx;
    logic signed [CoordBits-1:0] body_dz;
  } out_t;

  typedef struct packed {
    logic               sep;
    logic [1:0]         action;
    logic               sx;
    logic               sz;
    logic [RadBits-1:0] mx;
    logic [RadBits-1:0] mz;
  } tok_t;

  typedef struct packed {
    logic                 vld;
    tok_t                 tok;
    logic [2*RadBits-1:0] rad;
    logic [RemBits-1:0]   rem;
    logic [RadBits-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic               vld;
    logic               sep;
    logic [1:0]         action;
    logic               sx;
    logic               sz;
    logic [DivBits-1:0] dvs;
    logic [DivBits-1:0] rx;
    logic [DivBits-1:0] rz;
    logic [AmtBits-1:0] lx;
    logic [AmtBits-1:0] lz;
    logic [AmtBits-1:0] qx;
    logic [AmtBits-1:0] qz;
  } dv_t;

endpackage
`default_nettype wire

// ===== rtl/cos_sqrt_cell.sv =====
// One root bit of the pipelined integer square root
`default_nettype none
module cos_sqrt_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire cos_pkg::sq_t    d_i,
  output cos_pkg::sq_t         d_o
);

  logic [cos_pkg::RemBits+1:0] wide;
  logic [cos_pkg::RemBits+1:0] trial;
  logic [cos_pkg::RemBits+1:0] diff;
  logic                        ge;
  cos_pkg::sq_t                d_nxt;
  cos_pkg::sq_t                d_r;

  always_comb begin
    wide  = {d_i.rem, d_i.rad[2*cos_pkg::RadBits-1 -: 2]};
    trial = {2'b00, d_i.root, 2'b01};
    ge    = (wide >= trial);
    diff  = wide - trial;
    d_nxt      = d_i;
    d_nxt.rem  = ge ? diff[cos_pkg::RemBits-1:0] : wide[cos_pkg::RemBits-1:0];
    d_nxt.root = {d_i.root[cos_pkg::RadBits-2:0], ge};
    d_nxt.rad  = {d_i.rad[2*cos_pkg::RadBits-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

// ===== rtl/cos_div_cell.sv =====
// One quotient bit of the two pipelined push dividers
`default_nettype none
module cos_div_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire cos_pkg::dv_t    d_i,
  output cos_pkg::dv_t         d_o
);

  logic [cos_pkg::DivBits:0] wx;
  logic [cos_pkg::DivBits:0] wz;
  logic [cos_pkg::DivBits:0] dv;
  logic [cos_pkg::DivBits:0] sx;
  logic [cos_pkg::DivBits:0] sz;
  logic                      gx;
  logic                      gz;
  cos_pkg::dv_t              d_nxt;
  cos_pkg::dv_t              d_r;

  always_comb begin
    dv = {1'b0, d_i.dvs};
    wx = {d_i.rx, d_i.lx[cos_pkg::AmtBits-1]};
    wz = {d_i.rz, d_i.lz[cos_pkg::AmtBits-1]};
    gx = (wx >= dv);
    gz = (wz >= dv);
    sx = wx - dv;
    sz = wz - dv;
    d_nxt    = d_i;
    d_nxt.rx = gx ? sx[cos_pkg::DivBits-1:0] : wx[cos_pkg::DivBits-1:0];
    d_nxt.rz = gz ? sz[cos_pkg::DivBits-1:0] : wz[cos_pkg::DivBits-1:0];
    d_nxt.lx = {d_i.lx[cos_pkg::AmtBits-2:0], 1'b0};
    d_nxt.lz = {d_i.lz[cos_pkg::AmtBits-2:0], 1'b0};
    d_nxt.qx = {d_i.qx[cos_pkg::AmtBits-2:0], gx};
    d_nxt.qz = {d_i.qz[cos_pkg::AmtBits-2:0], gz};
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

// ===== rtl/circle_overlap_separation.sv =====
// Top level of the circle overlap separation pipeline
// Throughput: one item every cycle; busy is always low, the pipeline never stalls.
// The square root chain gives one root bit per cell, the divider chain one quotient bit per cell.
// The receiver cannot stall: each result is shown for one cycle with out_valid.
// Reset clears the radius and all valid bits; payload registers are not reset.
`default_nettype none
module circle_overlap_separation (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire cos_pkg::in_t           in_item,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [cos_pkg::RadBits-1:0]  cfg_obstacle_radius,
  output logic                        out_valid,
  output cos_pkg::out_t               out_item
);

  localparam int C  = cos_pkg::CoordBits;
  localparam int RB = cos_pkg::RadBits;
  localparam int MB = cos_pkg::MagBits;
  localparam int AB = cos_pkg::AmtBits;
  localparam int SW = AB + 2;
  localparam logic signed [SW-1:0] SatMax = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] SatMin = ~SatMax;

  function automatic logic [C-1:0] sat(input logic signed [SW-1:0] v);
    logic [C-1:0] r;
    if (v > SatMax) begin
      r = SatMax[C-1:0];
    end else if (v < SatMin) begin
      r = SatMin[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  logic [RB-1:0]     radius_r;
  logic [2*RB-1:0]   rsq_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_obstacle_radius;
    end
  end

  always_ff @(posedge clk) begin
    rsq_r <= radius_r * radius_r;
  end

  // front end: offsets and vertical span test
  logic signed [MB-1:0] dx;
  logic signed [MB-1:0] dz;
  logic signed [C:0]    ub;
  logic signed [C:0]    uo;
  logic signed [C:0]    by;
  logic signed [C:0]    oy;
  logic                 vert;

  always_comb begin
    dx   = MB'(in_item.body_x) - MB'(in_item.obstacle_x);
    dz   = MB'(in_item.body_z) - MB'(in_item.obstacle_z);
    by   = (C+1)'(in_item.body_y);
    oy   = (C+1)'(in_item.obstacle_y);
    ub   = by + $signed({2'b00, in_item.body_height});
    uo   = oy + $signed({2'b00, in_item.obstacle_height});
    vert = ((uo <= ub) && (uo >= by)) || ((ub <= uo) && (ub >= oy));
  end

  logic          v0_r;
  logic [MB-1:0] ax0_r;
  logic [MB-1:0] az0_r;
  logic          sx0_r;
  logic          sz0_r;
  logic          vt0_r;
  logic [1:0]    ac0_r;

  always_ff @(posedge clk) begin
    v0_r  <= start && !busy;
    ax0_r <= dx[MB-1] ? MB'(-dx) : MB'(dx);
    az0_r <= dz[MB-1] ? MB'(-dz) : MB'(dz);
    sx0_r <= dx[MB-1];
    sz0_r <= dz[MB-1];
    vt0_r <= vert;
    ac0_r <= in_item.action;
    if (!rst_n) begin
      v0_r <= 1'b0;
    end
  end

  logic            v1_r;
  logic [2*MB-1:0] sqx1_r;
  logic [2*MB-1:0] sqz1_r;
  logic [MB-1:0]   ax1_r;
  logic [MB-1:0]   az1_r;
  logic            sx1_r;
  logic            sz1_r;
  logic            vt1_r;
  logic [1:0]      ac1_r;

  always_ff @(posedge clk) begin
    v1_r   <= v0_r;
    sqx1_r <= ax0_r * ax0_r;
    sqz1_r <= az0_r * az0_r;
    ax1_r  <= ax0_r;
    az1_r  <= az0_r;
    sx1_r  <= sx0_r;
    sz1_r  <= sz0_r;
    vt1_r  <= vt0_r;
    ac1_r  <= ac0_r;
    if (!rst_n) begin
      v1_r <= 1'b0;
    end
  end

  logic [cos_pkg::SqBits-1:0] d2;
  logic                       sep2;
  cos_pkg::sq_t               sq_nxt;
  cos_pkg::sq_t               sq_r;

  always_comb begin
    d2   = cos_pkg::SqBits'(sqx1_r) + cos_pkg::SqBits'(sqz1_r);
    sep2 = vt1_r && (d2 <= cos_pkg::SqBits'(rsq_r));
    sq_nxt.vld        = v1_r;
    sq_nxt.tok.sep    = sep2;
    sq_nxt.tok.action = ac1_r;
    sq_nxt.tok.sx     = sx1_r;
    sq_nxt.tok.sz     = sz1_r;
    sq_nxt.tok.mx     = ax1_r[RB-1:0];
    sq_nxt.tok.mz     = az1_r[RB-1:0];
    sq_nxt.rad        = sep2 ? d2[2*RB-1:0] : '0;
    sq_nxt.rem        = '0;
    sq_nxt.root       = '0;
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
    if (!rst_n) begin
      sq_r.vld <= 1'b0;
    end
  end

  cos_pkg::sq_t sq_chain [RB+1];
  assign sq_chain[0] = sq_r;

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    cos_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_i   (sq_chain[i]),
      .d_o   (sq_chain[i+1])
    );
  end

  // push amount and divisor
  cos_pkg::sq_t       sq_e;
  cos_pkg::tok_t      tk_e;
  logic               zero;
  logic [RB-1:0]      rdist;
  logic               v3_r;
  cos_pkg::tok_t      tk3_r;
  logic [AB-1:0]      amt3_r;
  logic [RB:0]        dvs3_r;

  always_comb begin
    sq_e  = sq_chain[RB];
    zero  = (sq_e.root == '0);
    rdist = zero ? RB'(1) : sq_e.root;
    tk_e  = sq_e.tok;
    if (zero) begin
      tk_e.mx = RB'(1);
      tk_e.mz = '0;
      tk_e.sx = 1'b0;
      tk_e.sz = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    v3_r         <= sq_e.vld;
    tk3_r        <= tk_e;
    amt3_r       <= AB'(radius_r) - AB'(rdist) + (AB'(1) << cos_pkg::FracBits);
    dvs3_r       <= (sq_e.tok.action == cos_pkg::ACT_SHARE) ? {rdist, 1'b0} : {1'b0, rdist};
    if (!rst_n) begin
      v3_r <= 1'b0;
    end
  end

  logic               v4_r;
  cos_pkg::tok_t      tk4_r;
  logic [RB+AB-1:0]   px4_r;
  logic [RB+AB-1:0]   pz4_r;
  logic [RB:0]        dvs4_r;

  always_ff @(posedge clk) begin
    v4_r   <= v3_r;
    tk4_r  <= tk3_r;
    px4_r  <= tk3_r.mx * amt3_r;
    pz4_r  <= tk3_r.mz * amt3_r;
    dvs4_r <= dvs3_r;
    if (!rst_n) begin
      v4_r <= 1'b0;
    end
  end

  logic [cos_pkg::NumBits-1:0] nx;
  logic [cos_pkg::NumBits-1:0] nz;
  cos_pkg::dv_t                dv_nxt;
  cos_pkg::dv_t                dv_r;

  always_comb begin
    nx = {1'b0, px4_r} + cos_pkg::NumBits'(dvs4_r >> 1);
    nz = {1'b0, pz4_r} + cos_pkg::NumBits'(dvs4_r >> 1);
    dv_nxt.vld    = v4_r;
    dv_nxt.sep    = tk4_r.sep;
    dv_nxt.action = tk4_r.action;
    dv_nxt.sx     = tk4_r.sx;
    dv_nxt.sz     = tk4_r.sz;
    dv_nxt.dvs    = dvs4_r;
    dv_nxt.rx     = nx[cos_pkg::NumBits-1:AB];
    dv_nxt.rz     = nz[cos_pkg::NumBits-1:AB];
    dv_nxt.lx     = nx[AB-1:0];
    dv_nxt.lz     = nz[AB-1:0];
    dv_nxt.qx     = '0;
    dv_nxt.qz     = '0;
  end

  always_ff @(posedge clk) begin
    dv_r <= dv_nxt;
    if (!rst_n) begin
      dv_r.vld <= 1'b0;
    end
  end

  cos_pkg::dv_t dv_chain [AB+1];
  assign dv_chain[0] = dv_r;

  for (genvar j = 0; j < AB; j++) begin : g_div
    cos_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_i   (dv_chain[j]),
      .d_o   (dv_chain[j+1])
    );
  end

  // sign, route and saturate
  cos_pkg::dv_t         dv_e;
  logic signed [SW-1:0] vx;
  logic signed [SW-1:0] vz;
  cos_pkg::out_t        out_nxt;
  cos_pkg::out_t        out_r;
  logic                 out_valid_r;
  logic [1:0]           out_act_r;

  always_comb begin
    dv_e = dv_chain[AB];
    vx   = dv_e.sx ? -$signed({2'b00, dv_e.qx}) : $signed({2'b00, dv_e.qx});
    vz   = dv_e.sz ? -$signed({2'b00, dv_e.qz}) : $signed({2'b00, dv_e.qz});
    out_nxt.separated   = dv_e.sep;
    out_nxt.obstacle_dx = '0;
    out_nxt.obstacle_dz = '0;
    out_nxt.body_dx     = '0;
    out_nxt.body_dz     = '0;
    if (dv_e.sep) begin
      case (dv_e.action)
        cos_pkg::ACT_OBSTACLE: begin
          out_nxt.obstacle_dx = sat(-vx);
          out_nxt.obstacle_dz = sat(-vz);
        end
        cos_pkg::ACT_BODY: begin
          out_nxt.body_dx = sat(vx);
          out_nxt.body_dz = sat(vz);
        end
        cos_pkg::ACT_SHARE: begin
          out_nxt.obstacle_dx = sat(-vx);
          out_nxt.obstacle_dz = sat(-vz);
          out_nxt.body_dx     = sat(vx);
          out_nxt.body_dz     = sat(vz);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_valid_r <= dv_e.vld;
    out_r       <= out_nxt;
    out_act_r   <= dv_e.action;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_no_sep_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.separated) |->
      (out_item.obstacle_dx == '0 && out_item.obstacle_dz == '0 &&
       out_item.body_dx == '0 && out_item.body_dz == '0))
    else $error("move reported without separation");
  a_body_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_act_r == cos_pkg::ACT_BODY) |->
      (out_item.obstacle_dx == '0 && out_item.obstacle_dz == '0))
    else $error("obstacle moved in body mode");
  a_share_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_act_r == cos_pkg::ACT_SHARE) |->
      (out_item.obstacle_dx == -out_item.body_dx &&
       out_item.obstacle_dz == -out_item.body_dz))
    else $error("shared push not mirrored");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (v0_r && !busy))
    else $error("accepted item lost at pipeline entry");
`endif

endmodule
`default_nettype wire
